[hdl/ctb_pkg.sv]
`default_nettype none

package ctb_pkg;

    // fixed-point scales
    localparam int FRAC = 14;
    localparam logic [15:0] FB_THRESH = 16'd9460;

    // normaliser geometry
    localparam int VW       = 40;
    localparam int TOPW     = $clog2(VW);
    localparam int MW       = 30;
    localparam int SQ_W     = 64;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int SQ_PER   = 2;
    localparam int SQ_ST    = SQ_STEPS / SQ_PER;
    localparam int SQ_REMW  = SQ_W / 2 + 4;
    localparam int QW       = 16;
    localparam int DV_PER   = 2;
    localparam int DV_ST    = QW / DV_PER;
    localparam int DW       = MW + FRAC + 3;
    localparam int NORM_LAT = 5 + SQ_ST + 1 + DV_ST + 1;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] tangent_one_x;
        logic signed [15:0] tangent_one_y;
        logic signed [15:0] tangent_one_z;
        logic signed [15:0] tangent_two_x;
        logic signed [15:0] tangent_two_y;
        logic signed [15:0] tangent_two_z;
        logic               used_fallback;
    } t_out_beat;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_q14vec;

    // divide by 2^14, round half away from zero
    function automatic logic signed [63:0] rs14(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/ctb_norm.sv]
`default_nettype none

module ctb_norm import ctb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire logic    i_valid,
    input  wire t_vec    i_vec,
    output logic         o_valid,
    output t_q14vec      o_vec
);

    localparam int MD_FIRST = 4;
    localparam int MD_LAST  = 5 + SQ_ST;

    logic [NORM_LAT:1]       r_vld;
    logic [2:0]              r_sgn [1:NORM_LAT-1];
    logic                    r_any [1:NORM_LAT-1];

    logic signed [VW-1:0]    c [3];
    logic [VW-1:0]           r1_m [3];
    logic [VW-1:0]           r2_m [3];
    logic [TOPW-1:0]         r2_top;
    logic [MW-1:0]           r3_m [3];
    logic [2*MW-1:0]         r4_sq [3];
    logic [MW-1:0]           r_md [MD_FIRST:MD_LAST][3];

    logic [SQ_W-1:0]         r_sx    [0:SQ_ST];
    logic [SQ_REMW-1:0]      r_srem  [0:SQ_ST];
    logic [SQ_W/2-1:0]       r_sroot [0:SQ_ST];
    logic [SQ_W-1:0]         n_sx    [1:SQ_ST];
    logic [SQ_REMW-1:0]      n_srem  [1:SQ_ST];
    logic [SQ_W/2-1:0]       n_sroot [1:SQ_ST];

    logic [SQ_W/2-1:0]       r_dlen [0:DV_ST];
    logic [DW-1:0]           r_drem [0:DV_ST][3];
    logic [QW-1:0]           r_dq   [0:DV_ST][3];
    logic [DW-1:0]           n_drem [1:DV_ST][3];
    logic [QW-1:0]           n_dq   [1:DV_ST][3];

    logic [VW-1:0]           orv;
    logic [TOPW-1:0]         top;
    logic [MW-1:0]           shifted [3];
    t_q14vec                 r_out;

    assign c[0] = i_vec.x;
    assign c[1] = i_vec.y;
    assign c[2] = i_vec.z;

    // leading one of the largest magnitude is the leading one of their or
    always_comb begin
        orv = r1_m[0] | r1_m[1] | r1_m[2];
        top = '0;
        for (int j = 0; j < VW; j++) begin
            if (orv[j]) begin
                top = TOPW'(j);
            end
        end
    end

    // bring the largest magnitude into [2^29, 2^30)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (int'(r2_top) > MW - 1) begin
                shifted[i] = MW'(r2_m[i] >> (int'(r2_top) - (MW - 1)));
            end else begin
                shifted[i] = MW'(r2_m[i] << ((MW - 1) - int'(r2_top)));
            end
        end
    end

    // square root, two result bits per stage
    always_comb begin
        logic [SQ_W-1:0]    x;
        logic [SQ_REMW-1:0] rem;
        logic [SQ_REMW-1:0] trial;
        logic [SQ_W/2-1:0]  root;
        for (int s = 1; s <= SQ_ST; s++) begin
            x    = r_sx[s-1];
            rem  = r_srem[s-1];
            root = r_sroot[s-1];
            for (int t = 0; t < SQ_PER; t++) begin
                rem   = {rem[SQ_REMW-3:0], x[SQ_W-1:SQ_W-2]};
                x     = x << 2;
                trial = SQ_REMW'({root, 2'b01});
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[SQ_W/2-2:0], 1'b1};
                end else begin
                    root = {root[SQ_W/2-2:0], 1'b0};
                end
            end
            n_sx[s]    = x;
            n_srem[s]  = rem;
            n_sroot[s] = root;
        end
    end

    // restoring division, two quotient bits per stage
    always_comb begin
        logic [DW-1:0] rem;
        logic [DW-1:0] trial;
        logic [QW-1:0] q;
        for (int s = 1; s <= DV_ST; s++) begin
            for (int i = 0; i < 3; i++) begin
                rem = r_drem[s-1][i];
                q   = r_dq[s-1][i];
                for (int t = 0; t < DV_PER; t++) begin
                    trial = DW'(r_dlen[s-1]) << (QW - 1 - DV_PER * (s - 1) - t);
                    if (rem >= trial) begin
                        rem = rem - trial;
                        q[QW - 1 - DV_PER * (s - 1) - t] = 1'b1;
                    end
                end
                n_drem[s][i] = rem;
                n_dq[s][i]   = q;
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NORM_LAT-1:1], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_m[i] <= c[i][VW-1] ? VW'(-c[i]) : VW'(c[i]);
                r2_m[i] <= r1_m[i];
                r3_m[i] <= shifted[i];
                r4_sq[i] <= (2*MW)'(r3_m[i]) * (2*MW)'(r3_m[i]);
            end
            r2_top <= top;
            r_sgn[1] <= {c[2][VW-1], c[1][VW-1], c[0][VW-1]};
            r_any[1] <= (c[0] != '0) || (c[1] != '0) || (c[2] != '0);
            for (int k = 2; k < NORM_LAT; k++) begin
                r_sgn[k] <= r_sgn[k-1];
                r_any[k] <= r_any[k-1];
            end

            r_md[MD_FIRST] <= r3_m;
            for (int k = MD_FIRST + 1; k <= MD_LAST; k++) begin
                r_md[k] <= r_md[k-1];
            end

            r_sx[0]    <= SQ_W'(r4_sq[0]) + SQ_W'(r4_sq[1]) + SQ_W'(r4_sq[2]);
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            for (int s = 1; s <= SQ_ST; s++) begin
                r_sx[s]    <= n_sx[s];
                r_srem[s]  <= n_srem[s];
                r_sroot[s] <= n_sroot[s];
            end

            r_dlen[0] <= r_sroot[SQ_ST];
            for (int i = 0; i < 3; i++) begin
                r_drem[0][i] <= DW'({r_md[MD_LAST][i], {FRAC{1'b0}}})
                              + DW'(r_sroot[SQ_ST] >> 1);
                r_dq[0][i]   <= '0;
            end
            for (int s = 1; s <= DV_ST; s++) begin
                r_dlen[s] <= r_dlen[s-1];
                r_drem[s] <= n_drem[s];
                r_dq[s]   <= n_dq[s];
            end

            // zero vector normalises to zero
            if (r_any[NORM_LAT-1]) begin
                r_out.x <= r_sgn[NORM_LAT-1][0] ? -$signed(r_dq[DV_ST][0])
                                                 : $signed(r_dq[DV_ST][0]);
                r_out.y <= r_sgn[NORM_LAT-1][1] ? -$signed(r_dq[DV_ST][1])
                                                 : $signed(r_dq[DV_ST][1]);
                r_out.z <= r_sgn[NORM_LAT-1][2] ? -$signed(r_dq[DV_ST][2])
                                                 : $signed(r_dq[DV_ST][2]);
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_valid = r_vld[NORM_LAT];
    assign o_vec   = r_out;

endmodule

`default_nettype wire

[hdl/contact_tangent_basis.sv]
`default_nettype none

// Friction tangent basis per contact point: takes a Q2.14 normal and a Q16.16
// velocity beat and returns two Q2.14 tangents plus a fallback flag. Fully
// pipelined: one beat is accepted every cycle while no skid beat is held, and each
// passes 6 projection stages, two 31-stage normalisers each holding a 16-stage
// square root and an 8-stage divider, 2 cross-product stages, 1 output register.
// A stall on the output freezes the whole pipeline behind a one-beat skid
// register, so input ready is a register and never waits on output ready.

module contact_tangent_basis import ctb_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    logic                en;
    logic signed [15:0]  in_n [3];
    logic signed [31:0]  in_v [3];

    logic [6:1]          r_vld;
    logic signed [47:0]  r1_p [3];
    logic signed [15:0]  r1_n [3], r2_n [3], r3_n [3], r4_n [3], r5_n [3], r6_n [3];
    logic signed [31:0]  r1_v [3], r2_v [3], r3_v [3], r4_v [3];
    logic signed [49:0]  r2_dot;
    logic signed [35:0]  r3_d;
    logic signed [51:0]  r4_nd [3];
    logic signed [VW-1:0] r5_t [3];
    logic                r6_fb;
    t_vec                r6_vec;

    logic                fb;
    logic [16:0]         nx_mag;
    t_vec                n_vec;

    logic                n1_valid;
    t_q14vec             n1_vec;
    logic signed [15:0]  r_s1_n  [1:NORM_LAT][3];
    logic                r_s1_fb [1:NORM_LAT];

    logic                r7_vld;
    logic signed [31:0]  r7_cr [3];
    t_q14vec             r7_a;
    logic                r7_fb;

    logic                r8_vld;
    t_vec                r8_vec;
    t_q14vec             r8_bfb;
    t_q14vec             r8_a;
    logic                r8_fb;

    logic                n2_valid;
    t_q14vec             n2_vec;
    t_q14vec             r_s2_a   [1:NORM_LAT];
    t_q14vec             r_s2_bfb [1:NORM_LAT];
    logic                r_s2_fb  [1:NORM_LAT];

    t_out_beat           p_beat;
    logic                r_out_vld;
    logic                r_skid_vld;
    t_out_beat           r_out;
    t_out_beat           r_skid;
    logic                out_free;

    assign en = ~r_skid_vld;
    assign o_in_ready = en;

    assign in_n[0] = i_in_beat.normal_x;
    assign in_n[1] = i_in_beat.normal_y;
    assign in_n[2] = i_in_beat.normal_z;
    assign in_v[0] = i_in_beat.vel_x;
    assign in_v[1] = i_in_beat.vel_y;
    assign in_v[2] = i_in_beat.vel_z;

    // zero test and fixed basis from the normal
    always_comb begin
        fb     = (r5_t[0] == '0) && (r5_t[1] == '0) && (r5_t[2] == '0);
        nx_mag = r5_n[0][15] ? 17'(-$signed(17'(r5_n[0]))) : 17'(r5_n[0]);
        if (fb) begin
            if (nx_mag >= 17'(FB_THRESH)) begin
                n_vec.x = VW'(r5_n[1]);
                n_vec.y = -VW'(r5_n[0]);
                n_vec.z = '0;
            end else begin
                n_vec.x = '0;
                n_vec.y = VW'(r5_n[2]);
                n_vec.z = -VW'(r5_n[1]);
            end
        end else begin
            n_vec.x = r5_t[0];
            n_vec.y = r5_t[1];
            n_vec.z = r5_t[2];
        end
    end

    // projection and cross-product valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[5:1], i_in_valid};
            r7_vld <= n1_valid;
            r8_vld <= r7_vld;
        end
    end

    // projection: t = v - n * round(v . n)
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i] <= 48'(in_v[i]) * 48'(in_n[i]);
                r1_n[i] <= in_n[i];
                r1_v[i] <= in_v[i];
                r2_n[i] <= r1_n[i];
                r2_v[i] <= r1_v[i];
                r3_n[i] <= r2_n[i];
                r3_v[i] <= r2_v[i];
                r4_nd[i] <= 52'(r3_n[i]) * 52'(r3_d);
                r4_n[i] <= r3_n[i];
                r4_v[i] <= r3_v[i];
                r5_t[i] <= VW'(64'(r4_v[i]) - rs14(64'(r4_nd[i])));
                r5_n[i] <= r4_n[i];
                r6_n[i] <= r5_n[i];
            end
            r2_dot <= 50'(r1_p[0]) + 50'(r1_p[1]) + 50'(r1_p[2]);
            r3_d   <= 36'(rs14(64'(r2_dot)));
            r6_fb  <= fb;
            r6_vec <= n_vec;
        end
    end

    ctb_norm u_norm_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[6]),
        .i_vec   (r6_vec),
        .o_valid (n1_valid),
        .o_vec   (n1_vec)
    );

    // normal and flag alongside the first normaliser
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_n[1]  <= r6_n;
            r_s1_fb[1] <= r6_fb;
            for (int k = 2; k <= NORM_LAT; k++) begin
                r_s1_n[k]  <= r_s1_n[k-1];
                r_s1_fb[k] <= r_s1_fb[k-1];
            end
        end
    end

    // cross product a x n, then the rounded fallback n x a = -(a x n)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_cr[0] <= 32'(n1_vec.y) * 32'(r_s1_n[NORM_LAT][2])
                      - 32'(n1_vec.z) * 32'(r_s1_n[NORM_LAT][1]);
            r7_cr[1] <= 32'(n1_vec.z) * 32'(r_s1_n[NORM_LAT][0])
                      - 32'(n1_vec.x) * 32'(r_s1_n[NORM_LAT][2]);
            r7_cr[2] <= 32'(n1_vec.x) * 32'(r_s1_n[NORM_LAT][1])
                      - 32'(n1_vec.y) * 32'(r_s1_n[NORM_LAT][0]);
            r7_a  <= n1_vec;
            r7_fb <= r_s1_fb[NORM_LAT];

            r8_vec.x <= VW'(r7_cr[0]);
            r8_vec.y <= VW'(r7_cr[1]);
            r8_vec.z <= VW'(r7_cr[2]);
            r8_bfb.x <= sat16(rs14(-64'(r7_cr[0])));
            r8_bfb.y <= sat16(rs14(-64'(r7_cr[1])));
            r8_bfb.z <= sat16(rs14(-64'(r7_cr[2])));
            r8_a  <= r7_a;
            r8_fb <= r7_fb;
        end
    end

    ctb_norm u_norm_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_vld),
        .i_vec   (r8_vec),
        .o_valid (n2_valid),
        .o_vec   (n2_vec)
    );

    // first tangent and fallback alongside the second normaliser
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_a[1]   <= r8_a;
            r_s2_bfb[1] <= r8_bfb;
            r_s2_fb[1]  <= r8_fb;
            for (int k = 2; k <= NORM_LAT; k++) begin
                r_s2_a[k]   <= r_s2_a[k-1];
                r_s2_bfb[k] <= r_s2_bfb[k-1];
                r_s2_fb[k]  <= r_s2_fb[k-1];
            end
        end
    end

    // result assembly
    always_comb begin
        p_beat.tangent_one_x = r_s2_a[NORM_LAT].x;
        p_beat.tangent_one_y = r_s2_a[NORM_LAT].y;
        p_beat.tangent_one_z = r_s2_a[NORM_LAT].z;
        if (r_s2_fb[NORM_LAT]) begin
            p_beat.tangent_two_x = r_s2_bfb[NORM_LAT].x;
            p_beat.tangent_two_y = r_s2_bfb[NORM_LAT].y;
            p_beat.tangent_two_z = r_s2_bfb[NORM_LAT].z;
        end else begin
            p_beat.tangent_two_x = n2_vec.x;
            p_beat.tangent_two_y = n2_vec.y;
            p_beat.tangent_two_z = n2_vec.z;
        end
        p_beat.used_fallback = r_s2_fb[NORM_LAT];
    end

    // output register and skid beat
    assign out_free = ~r_out_vld | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= en & n2_valid;
            end
        end else if (en & n2_valid) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else begin
                r_out <= p_beat;
            end
        end else if (en & n2_valid) begin
            r_skid <= p_beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid beat held without an output beat");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_out_ready) |=> r_skid_vld)
        else $error("skid beat dropped while output stalled");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_out_ready && n2_valid))
        else $error("skid filled without a stalled output");
`endif

endmodule

`default_nettype wire
